/* hw/rtl/llrc_pkg.sv */
// shared types and constants of the laser line row centroid
package llrc_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_HUE_LOW  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_HIGH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_LOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VAL_HIGH = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTRE   = 3'd6;

  localparam logic [7:0]  HUE_LOW_RST  = 8'd0;
  localparam logic [7:0]  HUE_HIGH_RST = 8'd200;
  localparam logic [7:0]  SAT_LOW_RST  = 8'd150;
  localparam logic [7:0]  SAT_HIGH_RST = 8'd255;
  localparam logic [7:0]  VAL_LOW_RST  = 8'd150;
  localparam logic [7:0]  VAL_HIGH_RST = 8'd255;
  localparam logic [10:0] CENTRE_RST   = 11'd320;

  localparam logic [8:0] HUE_WRAP = 9'd180;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic       frame_end;
  } pixel_t;

  typedef struct packed {
    logic [10:0]        row_index;
    logic signed [11:0] line_offset;
    logic [11:0]        lit_count;
  } result_t;

  typedef struct packed {
    logic [7:0] hue_low;
    logic [7:0] hue_high;
    logic [7:0] sat_low;
    logic [7:0] sat_high;
    logic [7:0] val_low;
    logic [7:0] val_high;
  } thresh_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_OUT
  } back_state_t;

endpackage

/* hw/rtl/laser_line_row_centroid.sv */
// top level: laser line row centroid
// pixels: one per cycle unless stalled, through a three-stage classify and accumulate pipeline
// row result: a row's totals go through the queue into the one-bit-a-cycle divider, whose
//   SW = clog2(MAX_COLS) + clog2(MAX_COLS+1) steps end with out_valid raised
// the divider takes a row only once the last result has left; a four-entry queue holds finished rows and
//   pixels stall only while a row end waits on a full queue; sync active-low reset clears state
module laser_line_row_centroid #(
  parameter int MAX_COLS = 2048,
  parameter int MAX_ROWS = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  llrc_pkg::pixel_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output llrc_pkg::result_t                   out_data,
  input  logic                                cfg_we,
  input  logic [llrc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [llrc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam int CW = $clog2(MAX_COLS);
  localparam int LW = $clog2(MAX_COLS + 1);
  localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int SW = CW + LW;
  localparam int QW = RW + SW + LW;

  llrc_pkg::thresh_t thr_r;
  logic [10:0] centre_r;

  logic          push_valid, pop, q_full, q_empty;
  logic [RW-1:0] push_row;
  logic [SW-1:0] push_sum;
  logic [LW-1:0] push_cnt;
  logic [QW-1:0] q_rd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r.hue_low  <= llrc_pkg::HUE_LOW_RST;
      thr_r.hue_high <= llrc_pkg::HUE_HIGH_RST;
      thr_r.sat_low  <= llrc_pkg::SAT_LOW_RST;
      thr_r.sat_high <= llrc_pkg::SAT_HIGH_RST;
      thr_r.val_low  <= llrc_pkg::VAL_LOW_RST;
      thr_r.val_high <= llrc_pkg::VAL_HIGH_RST;
      centre_r       <= llrc_pkg::CENTRE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        llrc_pkg::CFG_HUE_LOW:  thr_r.hue_low  <= cfg_wdata[7:0];
        llrc_pkg::CFG_HUE_HIGH: thr_r.hue_high <= cfg_wdata[7:0];
        llrc_pkg::CFG_SAT_LOW:  thr_r.sat_low  <= cfg_wdata[7:0];
        llrc_pkg::CFG_SAT_HIGH: thr_r.sat_high <= cfg_wdata[7:0];
        llrc_pkg::CFG_VAL_LOW:  thr_r.val_low  <= cfg_wdata[7:0];
        llrc_pkg::CFG_VAL_HIGH: thr_r.val_high <= cfg_wdata[7:0];
        llrc_pkg::CFG_CENTRE:   centre_r       <= cfg_wdata;
        default: ;
      endcase
    end
  end

  llrc_front #(
    .MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .CW(CW), .LW(LW), .RW(RW), .SW(SW)
  ) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .thr(thr_r), .q_full(q_full),
    .push_valid(push_valid), .push_row(push_row), .push_sum(push_sum), .push_cnt(push_cnt)
  );

  llrc_queue #(.W(QW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push_valid), .wr_data({push_row, push_sum, push_cnt}),
    .pop(pop), .rd_data(q_rd), .full(q_full), .empty(q_empty)
  );

  llrc_back #(.CW(CW), .LW(LW), .RW(RW), .SW(SW)) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_empty(q_empty), .pop(pop),
    .q_row(q_rd[QW-1 -: RW]), .q_sum(q_rd[LW +: SW]), .q_cnt(q_rd[LW-1:0]),
    .centre(centre_r),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

endmodule

/* hw/rtl/llrc_front.sv */
// pixel classifier pipeline and per-row accumulation
module llrc_front #(
  parameter int MAX_COLS = 2048,
  parameter int MAX_ROWS = 2048,
  parameter int CW = 11,
  parameter int LW = 12,
  parameter int RW = 11,
  parameter int SW = 23
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  llrc_pkg::pixel_t  in_data,
  input  llrc_pkg::thresh_t thr,
  input  logic              q_full,
  output logic              push_valid,
  output logic [RW-1:0]     push_row,
  output logic [SW-1:0]     push_sum,
  output logic [LW-1:0]     push_cnt
);

  logic [7:0] mx, mn, dif;
  logic signed [18:0] b_s, g_s, r_s, d_s, t_a, nh_s;
  logic [16:0] ns_a;
  logic v_ok_a;
  logic adv;

  logic        s1_valid_r, s1_flat_r, s1_black_r, s1_vok_r, s1_row_end_r, s1_frame_end_r;
  logic [16:0] s1_ns_r, s1_nh_r;
  logic [8:0]  s1_ds_r, s1_dh_r;

  logic        s2_valid_r, s2_flat_r, s2_black_r, s2_vok_r, s2_row_end_r, s2_frame_end_r;
  logic [16:0] s2_ns_r, s2_nh_r, s2_ps_lo_r, s2_ph_lo_r, s2_ph_wrap_r;
  logic [17:0] s2_ps_hi_r, s2_ph_hi_r;

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [LW-1:0] cnt_r, cnt_nxt, cnt_add;
  logic [SW-1:0] sum_r, sum_nxt, sum_add;
  logic          full_r, full_nxt;
  logic          sat_ok, hue_ok, hue_zero, lit, s2_end;

  always_comb begin
    mx = in_data.blue;
    if (in_data.green > mx) mx = in_data.green;
    if (in_data.red > mx) mx = in_data.red;
    mn = in_data.blue;
    if (in_data.green < mn) mn = in_data.green;
    if (in_data.red < mn) mn = in_data.red;
    dif = mx - mn;
    b_s = {11'b0, in_data.blue};
    g_s = {11'b0, in_data.green};
    r_s = {11'b0, in_data.red};
    d_s = {11'b0, dif};
    if (mx == in_data.red) begin
      t_a = 19'sd30 * (g_s - b_s);
      if (t_a < 19'sd0) t_a = t_a + 19'sd180 * d_s;
    end else if (mx == in_data.green) begin
      t_a = 19'sd30 * (b_s - r_s) + 19'sd60 * d_s;
    end else begin
      t_a = 19'sd30 * (r_s - g_s) + 19'sd120 * d_s;
    end
    nh_s   = 19'sd2 * t_a + d_s;
    ns_a   = 17'd510 * {9'b0, dif} + {9'b0, mx};
    v_ok_a = (mx >= thr.val_low) && (mx <= thr.val_high);
  end

  assign s2_end   = s2_row_end_r || s2_frame_end_r;
  assign adv      = !(s2_valid_r && s2_end && q_full);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_ns_r        <= ns_a;
      s1_ds_r        <= {mx, 1'b0};
      s1_nh_r        <= nh_s[16:0];
      s1_dh_r        <= {dif, 1'b0};
      s1_flat_r      <= (dif == 8'd0);
      s1_black_r     <= (mx == 8'd0);
      s1_vok_r       <= v_ok_a;
      s1_row_end_r   <= in_data.row_end;
      s1_frame_end_r <= in_data.frame_end;

      s2_ns_r        <= s1_ns_r;
      s2_nh_r        <= s1_nh_r;
      s2_ps_lo_r     <= {8'b0, s1_ds_r} * {9'b0, thr.sat_low};
      s2_ps_hi_r     <= {9'b0, s1_ds_r} * ({10'b0, thr.sat_high} + 18'd1);
      s2_ph_lo_r     <= {8'b0, s1_dh_r} * {9'b0, thr.hue_low};
      s2_ph_hi_r     <= {9'b0, s1_dh_r} * ({10'b0, thr.hue_high} + 18'd1);
      s2_ph_wrap_r   <= {8'b0, s1_dh_r} * {8'b0, llrc_pkg::HUE_WRAP};
      s2_flat_r      <= s1_flat_r;
      s2_black_r     <= s1_black_r;
      s2_vok_r       <= s1_vok_r;
      s2_row_end_r   <= s1_row_end_r;
      s2_frame_end_r <= s1_frame_end_r;
    end
  end

  always_comb begin
    sat_ok   = (s2_ns_r >= s2_ps_lo_r) && ({1'b0, s2_ns_r} < s2_ps_hi_r);
    hue_zero = s2_flat_r || (s2_nh_r >= s2_ph_wrap_r);
    hue_ok   = hue_zero ? (thr.hue_low == 8'd0)
                        : ((s2_nh_r >= s2_ph_lo_r) && ({1'b0, s2_nh_r} < s2_ph_hi_r));
    lit      = !full_r && !s2_black_r && s2_vok_r && sat_ok && hue_ok;

    cnt_add  = lit ? cnt_r + LW'(1) : cnt_r;
    sum_add  = lit ? sum_r + {{(SW-CW){1'b0}}, col_r} : sum_r;

    col_nxt  = col_r;
    full_nxt = full_r;
    if (!full_r) begin
      if (col_r == CW'(MAX_COLS - 1)) full_nxt = 1'b1;
      else col_nxt = col_r + CW'(1);
    end
    cnt_nxt = cnt_add;
    sum_nxt = sum_add;
    row_nxt = row_r;
    if (s2_end) begin
      col_nxt  = '0;
      full_nxt = 1'b0;
      cnt_nxt  = '0;
      sum_nxt  = '0;
      if (s2_frame_end_r) row_nxt = '0;
      else if (row_r != RW'(MAX_ROWS - 1)) row_nxt = row_r + RW'(1);
    end
  end

  assign push_valid = s2_valid_r && s2_end && adv && (cnt_add != '0);
  assign push_row   = row_r;
  assign push_sum   = sum_add;
  assign push_cnt   = cnt_add;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      cnt_r  <= '0;
      sum_r  <= '0;
      full_r <= 1'b0;
    end else if (adv && s2_valid_r) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      cnt_r  <= cnt_nxt;
      sum_r  <= sum_nxt;
      full_r <= full_nxt;
    end
  end

endmodule

/* hw/rtl/llrc_queue.sv */
// short request queue between the row accumulator and the divider
module llrc_queue #(
  parameter int W = 46
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full    = (cnt_r == (PW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop) rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

/* hw/rtl/llrc_back.sv */
// serial mean divider and result register
module llrc_back #(
  parameter int CW = 11,
  parameter int LW = 12,
  parameter int RW = 11,
  parameter int SW = 23
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  output logic              pop,
  input  logic [RW-1:0]     q_row,
  input  logic [SW-1:0]     q_sum,
  input  logic [LW-1:0]     q_cnt,
  input  logic [10:0]       centre,
  output logic              out_valid,
  input  logic              out_stall,
  output llrc_pkg::result_t out_data
);

  localparam int NW = (SW > 1) ? $clog2(SW) : 1;

  llrc_pkg::back_state_t state_r, state_nxt;
  logic [RW-1:0] row_r;
  logic [SW-1:0] quo_r;
  logic [LW-1:0] div_r;
  logic [LW-1:0] rem_r;
  logic [NW-1:0] step_r;
  logic [LW:0]   rem_sh, rem_sub;
  logic          ge;
  logic [RW+10:0] row_w;
  logic [CW+11:0] mean_w;
  logic [LW+11:0] cnt_w;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      llrc_pkg::BK_IDLE: if (!q_empty) state_nxt = llrc_pkg::BK_DIV;
      llrc_pkg::BK_DIV:  if (step_r == NW'(SW - 1)) state_nxt = llrc_pkg::BK_OUT;
      llrc_pkg::BK_OUT:  if (!out_stall) state_nxt = llrc_pkg::BK_IDLE;
      default:           state_nxt = llrc_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop       = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      llrc_pkg::BK_IDLE: pop = !q_empty;
      llrc_pkg::BK_OUT:  out_valid = 1'b1;
      default: begin
        pop       = 1'b0;
        out_valid = 1'b0;
      end
    endcase
  end

  always_comb begin
    rem_sh  = {rem_r, quo_r[SW-1]};
    ge      = rem_sh >= {1'b0, div_r};
    rem_sub = rem_sh - {1'b0, div_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= llrc_pkg::BK_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      row_r  <= q_row;
      quo_r  <= q_sum;
      div_r  <= q_cnt;
      rem_r  <= '0;
      step_r <= '0;
    end else if (state_r == llrc_pkg::BK_DIV) begin
      rem_r  <= ge ? rem_sub[LW-1:0] : rem_sh[LW-1:0];
      quo_r  <= {quo_r[SW-2:0], ge};
      step_r <= step_r + NW'(1);
    end
  end

  always_comb begin
    row_w  = {11'b0, row_r};
    mean_w = {12'b0, quo_r[CW-1:0]};
    cnt_w  = {12'b0, div_r};
    out_data.row_index   = row_w[10:0];
    out_data.line_offset = mean_w[11:0] - {1'b0, centre};
    out_data.lit_count   = cnt_w[11:0];
  end

endmodule

/* hw/rtl/llrc_checker.sv */
// port-level checks of the laser line row centroid
module llrc_checker #(
  parameter int MAX_COLS = 2048
) (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_stall,
  input llrc_pkg::result_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (MAX_COLS >= 4096) || (out_data.lit_count <= 12'(MAX_COLS)))
    else $error("lit count above row length");

endmodule

bind laser_line_row_centroid llrc_checker #(.MAX_COLS(MAX_COLS)) u_llrc_checker (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_data(out_data)
);
